// File: sv/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants for the byte ring buffer
// Sizes, request codes, the size report struct and pointer arithmetic.
// ----------------------------------------------------------------------------
package brb_pkg;

    // Storage geometry
    localparam int DEPTH     = 4096;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SIZE_W    = ADDR_W + 1;
    localparam int MAX_BURST = 64;
    localparam int CNT_W     = $clog2(MAX_BURST + 1);

    // Fixed field widths of the item ports
    localparam int REQ_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 12;
    localparam int CFG_W   = 13;

    // Register reset and size limits
    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(4096);
    localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(DEPTH);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SKIP    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DISCARD = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd6;

    // Size report, as seen on every result
    typedef struct packed {
        logic [FIELD_W-1:0] used;
        logic [FIELD_W-1:0] free;
        logic [FIELD_W-1:0] contig_push;
        logic [FIELD_W-1:0] contig_pop;
    } t_sizes;

    // Move a pointer forward by n slots, wrapping at s (p < s, n < s)
    function automatic logic [ADDR_W-1:0] brb_advance(
        input logic [ADDR_W-1:0] p,
        input logic [SIZE_W-1:0] n,
        input logic [SIZE_W-1:0] s
    );
        logic [SIZE_W-1:0] q;
        q = {1'b0, p} + n;
        if (q >= s) begin
            q = q - s;
        end
        return q[ADDR_W-1:0];
    endfunction

endpackage

// File: sv/brb_sizes.sv
// ----------------------------------------------------------------------------
// brb_sizes: occupancy report of the ring
// Held, free and contiguous spans from the two pointers and the ring size.
// ----------------------------------------------------------------------------
module brb_sizes
    import brb_pkg::*;
(
    input  logic [ADDR_W-1:0] i_front,
    input  logic [ADDR_W-1:0] i_rear,
    input  logic [SIZE_W-1:0] i_size,
    output t_sizes            o_sizes
);

    logic              w_le;
    logic [SIZE_W-1:0] w_front;
    logic [SIZE_W-1:0] w_rear;
    logic [SIZE_W-1:0] w_used;
    logic [SIZE_W-1:0] w_free;
    logic [SIZE_W-1:0] w_cpush;
    logic [SIZE_W-1:0] w_cpop;

    assign w_front = {1'b0, i_front};
    assign w_rear  = {1'b0, i_rear};
    assign w_le    = (i_front <= i_rear);

    // Held and free counts; one slot always stays empty
    assign w_used = w_le ? (w_rear - w_front) : (w_rear + i_size - w_front);
    assign w_free = i_size - SIZE_W'(1) - w_used;

    // Spans up to the wrap point
    always_comb begin
        if (w_le) begin
            w_cpush = (i_front == '0) ? (i_size - w_rear - SIZE_W'(1))
                                      : (i_size - w_rear);
            w_cpop  = w_rear - w_front;
        end else begin
            w_cpush = w_front - w_rear - SIZE_W'(1);
            w_cpop  = i_size - w_front;
        end
    end

    assign o_sizes.used        = FIELD_W'(w_used);
    assign o_sizes.free        = FIELD_W'(w_free);
    assign o_sizes.contig_push = FIELD_W'(w_cpush);
    assign o_sizes.contig_pop  = FIELD_W'(w_cpop);

endmodule

// File: sv/byte_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_unit: circular byte queue with one slot kept empty
// Push, burst read and peek, skip, discard, size query and clear.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  request  | in        | i_in_valid / o_in_stall   | req_type, data_byte, amount
//  result   | out       | o_out_valid / i_out_stall | out_byte .. contig_pop
//  config   | in        | i_cfg_valid / o_cfg_ready | buffer_size (i_cfg_data)
//
// Push, skip, discard, query and clear give one result each.
// Read and peek make one store read per byte per cycle while the result side
// does not stall. After reset the store is zeroed in a pass over all slots;
// requests are held off then, configuration writes are still taken.
// A stall on the result side holds byte issue; two result stages sit in between.
// ----------------------------------------------------------------------------
module byte_ring_buffer_unit
    import brb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic [FIELD_W-1:0] i_amount,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_byte_valid,
    output logic               o_last,
    output logic [FIELD_W-1:0] o_moved_count,
    output logic [FIELD_W-1:0] o_used_size,
    output logic [FIELD_W-1:0] o_free_size,
    output logic [FIELD_W-1:0] o_contig_push,
    output logic [FIELD_W-1:0] o_contig_pop,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;

    // Control state
    logic [1:0]         r_state,    n_state;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [CFG_W-1:0]   r_buf_size, n_buf_size;
    logic [ADDR_W-1:0]  r_front,    n_front;
    logic [ADDR_W-1:0]  r_rear,     n_rear;
    logic [ADDR_W-1:0]  r_rd_ptr,   n_rd_ptr;
    logic [CNT_W-1:0]   r_left,     n_left;
    logic [FIELD_W-1:0] r_moved,    n_moved;
    logic               r_burst,    n_burst;

    // Result stage 1 (store read in flight) and output register
    logic               r_s1_valid, n_s1_valid;
    logic               r_s1_byte;
    logic               r_s1_last;
    logic [FIELD_W-1:0] r_s1_moved;
    t_sizes             r_s1_sizes;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_bvalid;
    logic               r_out_last;
    logic [FIELD_W-1:0] r_out_moved;
    t_sizes             r_out_sizes;

    // Byte store
    logic [BYTE_W-1:0]  r_mem [DEPTH];
    logic [BYTE_W-1:0]  r_rd_data;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [BYTE_W-1:0]  w_wdata;
    logic               w_ren;

    logic [SIZE_W-1:0]  w_size;
    t_sizes             w_sz;
    logic               w_accept;
    logic               w_out_free;
    logic               w_issue;
    logic               w_issue_last;
    logic [FIELD_W-1:0] w_clip_used;
    logic [FIELD_W-1:0] w_clip_free;
    logic [CNT_W-1:0]   w_burst_n;

    // Effective ring size, clamped to 2 .. DEPTH
    always_comb begin
        if (SIZE_W'(r_buf_size) < SIZE_MIN) begin
            w_size = SIZE_MIN;
        end else if (SIZE_W'(r_buf_size) > SIZE_MAX) begin
            w_size = SIZE_MAX;
        end else begin
            w_size = SIZE_W'(r_buf_size);
        end
    end

    brb_sizes u_sizes (
        .i_front (r_front),
        .i_rear  (r_rear),
        .i_size  (w_size),
        .o_sizes (w_sz)
    );

    // Handshakes
    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign w_accept     = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_issue      = (r_state == ST_ISSUE) && (!r_s1_valid || w_out_free);
    assign w_issue_last = !r_burst || (r_left == CNT_W'(1));

    // Amount clipping
    assign w_clip_used = (i_amount > w_sz.used) ? w_sz.used : i_amount;
    assign w_clip_free = (i_amount > w_sz.free) ? w_sz.free : i_amount;
    assign w_burst_n   = (w_clip_used > FIELD_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                            : CNT_W'(w_clip_used);

    // Sequencer: clearing pass, request decode, result issue
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_buf_size = r_buf_size;
        n_front    = r_front;
        n_rear     = r_rear;
        n_rd_ptr   = r_rd_ptr;
        n_left     = r_left;
        n_moved    = r_moved;
        n_burst    = r_burst;
        w_we       = 1'b0;
        w_waddr    = r_rear;
        w_wdata    = i_data_byte;
        w_ren      = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_ISSUE;
                    n_burst = 1'b0;
                    n_moved = '0;
                    case (i_req_type)
                        REQ_PUSH: begin
                            if (w_sz.free != '0) begin
                                w_we    = 1'b1;
                                n_rear  = brb_advance(r_rear, SIZE_W'(1), w_size);
                                n_moved = FIELD_W'(1);
                            end
                        end
                        REQ_READ, REQ_PEEK: begin
                            n_moved  = FIELD_W'(w_burst_n);
                            n_left   = w_burst_n;
                            n_rd_ptr = r_front;
                            n_burst  = (w_burst_n != '0);
                            if (i_req_type == REQ_READ) begin
                                n_front = brb_advance(r_front, SIZE_W'(w_burst_n), w_size);
                            end
                        end
                        REQ_SKIP: begin
                            n_moved = w_clip_free;
                            n_rear  = brb_advance(r_rear, SIZE_W'(w_clip_free), w_size);
                        end
                        REQ_DISCARD: begin
                            n_moved = w_clip_used;
                            n_front = brb_advance(r_front, SIZE_W'(w_clip_used), w_size);
                        end
                        REQ_CLEAR: begin
                            n_front = '0;
                            n_rear  = '0;
                        end
                        default: begin
                            // query and unused codes only report sizes
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                if (w_issue) begin
                    if (r_burst) begin
                        w_ren    = 1'b1;
                        n_rd_ptr = brb_advance(r_rd_ptr, SIZE_W'(1), w_size);
                        n_left   = r_left - CNT_W'(1);
                    end
                    if (w_issue_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a size write restarts the ring
        if (i_cfg_valid) begin
            n_buf_size = i_cfg_data;
            n_front    = '0;
            n_rear     = '0;
        end
    end

    // Stage 1 occupancy
    always_comb begin
        if (w_issue) begin
            n_s1_valid = 1'b1;
        end else if (w_out_free) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_buf_size  <= CFG_RESET;
            r_front     <= '0;
            r_rear      <= '0;
            r_rd_ptr    <= '0;
            r_left      <= '0;
            r_burst     <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_buf_size  <= n_buf_size;
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_rd_ptr    <= n_rd_ptr;
            r_left      <= n_left;
            r_burst     <= n_burst;
            r_s1_valid  <= n_s1_valid;
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        r_moved <= n_moved;
        if (w_issue) begin
            r_s1_byte  <= r_burst;
            r_s1_last  <= w_issue_last;
            r_s1_moved <= r_moved;
            r_s1_sizes <= w_sz;
        end
        if (w_out_free && r_s1_valid) begin
            r_out_byte   <= r_s1_byte ? r_rd_data : '0;
            r_out_bvalid <= r_s1_byte;
            r_out_last   <= r_s1_last;
            r_out_moved  <= r_s1_moved;
            r_out_sizes  <= r_s1_sizes;
        end
    end

    // Byte store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_ren) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_out_bvalid;
    assign o_last        = r_out_last;
    assign o_moved_count = r_out_moved;
    assign o_used_size   = r_out_sizes.used;
    assign o_free_size   = r_out_sizes.free;
    assign o_contig_push = r_out_sizes.contig_push;
    assign o_contig_pop  = r_out_sizes.contig_pop;

endmodule

// File: sv/brb_checker.sv
// ----------------------------------------------------------------------------
// brb_checker: port-level checks for the byte ring buffer
// Watches the top level's ports; attached by the bind below.
// ----------------------------------------------------------------------------
module brb_checker
    import brb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [BYTE_W-1:0]  o_out_byte,
    input logic               o_byte_valid,
    input logic               o_last,
    input logic [FIELD_W-1:0] o_moved_count,
    input logic [FIELD_W-1:0] o_used_size,
    input logic [FIELD_W-1:0] o_free_size,
    input logic [FIELD_W-1:0] o_contig_push,
    input logic [FIELD_W-1:0] o_contig_pop
);

    // requests are held off while the store is being zeroed after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken straight after reset");

    // a pending result is not withdrawn under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a result without a byte is always the only one of its item
    a_nobyte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_last && (o_out_byte == '0))
        else $error("byte-less result not final or not zero");

    // contiguous spans never exceed the totals
    a_spans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_contig_pop <= o_used_size) && (o_contig_push <= o_free_size))
        else $error("contiguous span larger than total");

    // a burst byte always counts as moved
    a_burst_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> (o_moved_count != '0))
        else $error("byte delivered with zero moved count");

endmodule

bind byte_ring_buffer_unit brb_checker u_brb_checker (.*);

// File: tb/tb_byte_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_unit: self-checking bench for the byte ring buffer
// A queue-fed driver offers requests with random gaps and a monitor checks
// every result against a shadow copy of the store and pointers, field by
// field. The slot count is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_unit;
    import brb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned LONG_HOLD    = 200;
    localparam int unsigned CYCLE_LIMIT  = 8000000;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [BYTE_W-1:0]  data;
        logic [FIELD_W-1:0] amount;
    } t_brb_req;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last_flag;
        logic [FIELD_W-1:0] moved;
        logic [FIELD_W-1:0] used;
        logic [FIELD_W-1:0] room;
        logic [FIELD_W-1:0] push_span;
        logic [FIELD_W-1:0] pop_span;
    } t_brb_result;

    // Clock, reset and block inputs, all known from time zero
    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    logic [REQ_W-1:0]   in_req    = '0;
    logic [BYTE_W-1:0]  in_data   = '0;
    logic [FIELD_W-1:0] in_amount = '0;
    logic               out_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [BYTE_W-1:0]  o_out_byte;
    logic               o_byte_valid;
    logic               o_last;
    logic [FIELD_W-1:0] o_moved_count;
    logic [FIELD_W-1:0] o_used_size;
    logic [FIELD_W-1:0] o_free_size;
    logic [FIELD_W-1:0] o_contig_push;
    logic [FIELD_W-1:0] o_contig_pop;
    logic               o_cfg_ready;

    // Shadow state of the buffer
    logic [BYTE_W-1:0]  shadow_store [DEPTH];
    int unsigned        shadow_front = 0;
    int unsigned        shadow_rear  = 0;
    logic [CFG_W-1:0]   shadow_size  = CFG_RESET;

    t_brb_req           pending_requests [$];
    t_brb_result        expected_results [$];
    t_brb_req           cur_request;

    int unsigned        gap_left     = 0;
    logic               jitter_on    = 1'b1;
    int unsigned        hold_asked   = 0;
    int unsigned        hold_seen    = 0;
    int unsigned        hold_left    = 0;
    int unsigned        stall_left   = 0;
    int unsigned        error_count  = 0;
    int unsigned        result_count = 0;
    int unsigned        cycle_count  = 0;

    byte_ring_buffer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (in_req),
        .i_data_byte   (in_data),
        .i_amount      (in_amount),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last        (o_last),
        .o_moved_count (o_moved_count),
        .o_used_size   (o_used_size),
        .o_free_size   (o_free_size),
        .o_contig_push (o_contig_push),
        .o_contig_pop  (o_contig_pop),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ---- shadow arithmetic --------------------------------------------------

    // Slot count in force: register value clamped to 2..DEPTH
    function automatic int unsigned slot_count();
        int unsigned s;
        s = shadow_size;
        if (s < 2) s = 2;
        if (s > DEPTH) s = DEPTH;
        return s;
    endfunction

    function automatic int unsigned held_bytes(input int unsigned s);
        if (shadow_front <= shadow_rear) return shadow_rear - shadow_front;
        return shadow_rear + s - shadow_front;
    endfunction

    function automatic int unsigned room_bytes(input int unsigned s);
        return s - 1 - held_bytes(s);
    endfunction

    function automatic int unsigned step_ptr(input int unsigned p, input int unsigned n,
                                             input int unsigned s);
        int unsigned q;
        q = p + n;
        return (q >= s) ? q - s : q;
    endfunction

    // Queue one expected result, sizes taken from the current shadow state
    function automatic void add_result(input logic [BYTE_W-1:0] b, input logic vld,
                                       input logic lst, input int unsigned moved,
                                       input int unsigned s);
        t_brb_result r;
        r.out_byte   = b;
        r.byte_valid = vld;
        r.last_flag  = lst;
        r.moved      = FIELD_W'(moved);
        r.used       = FIELD_W'(held_bytes(s));
        r.room       = FIELD_W'(room_bytes(s));
        if (shadow_front <= shadow_rear)
            r.push_span = FIELD_W'((shadow_front == 0) ? s - shadow_rear - 1 : s - shadow_rear);
        else
            r.push_span = FIELD_W'(shadow_front - shadow_rear - 1);
        r.pop_span   = FIELD_W'((shadow_front <= shadow_rear) ? shadow_rear - shadow_front
                                                                : s - shadow_front);
        expected_results.push_back(r);
    endfunction

    // Apply one accepted request to the shadow and queue its results
    function automatic void predict_request(input t_brb_req rq);
        int unsigned s, n, p, i;
        s = slot_count();
        case (rq.req)
            REQ_PUSH: begin
                n = 0;
                if (room_bytes(s) > 0) begin
                    shadow_store[shadow_rear] = rq.data;
                    shadow_rear = step_ptr(shadow_rear, 1, s);
                    n = 1;
                end
                add_result('0, 1'b0, 1'b1, n, s);
            end
            REQ_READ, REQ_PEEK: begin
                n = rq.amount;
                if (n > MAX_BURST) n = MAX_BURST;
                if (n > held_bytes(s)) n = held_bytes(s);
                if (n == 0) begin
                    add_result('0, 1'b0, 1'b1, 0, s);
                end else begin
                    p = shadow_front;
                    if (rq.req == REQ_READ) shadow_front = step_ptr(shadow_front, n, s);
                    for (i = 0; i < n; i++) begin
                        add_result(shadow_store[p], 1'b1, (i + 1 == n), n, s);
                        p = step_ptr(p, 1, s);
                    end
                end
            end
            REQ_SKIP: begin
                n = rq.amount;
                if (n > room_bytes(s)) n = room_bytes(s);
                shadow_rear = step_ptr(shadow_rear, n, s);
                add_result('0, 1'b0, 1'b1, n, s);
            end
            REQ_DISCARD: begin
                n = rq.amount;
                if (n > held_bytes(s)) n = held_bytes(s);
                shadow_front = step_ptr(shadow_front, n, s);
                add_result('0, 1'b0, 1'b1, n, s);
            end
            REQ_CLEAR: begin
                shadow_front = 0;
                shadow_rear  = 0;
                add_result('0, 1'b0, 1'b1, 0, s);
            end
            // query, and the unused code behaves as a query
            default: add_result('0, 1'b0, 1'b1, 0, s);
        endcase
    endfunction

    // ---- stimulus helpers ---------------------------------------------------

    function automatic t_brb_req make_request(input logic [REQ_W-1:0] req,
                                              input logic [BYTE_W-1:0] data,
                                              input logic [FIELD_W-1:0] amount);
        t_brb_req rq;
        rq.req    = req;
        rq.data   = data;
        rq.amount = amount;
        return rq;
    endfunction

    // Random request, skip and discard amounts biased towards the live slot count
    function automatic t_brb_req rand_request(input int unsigned slots);
        t_brb_req rq;
        int unsigned pick, bias, span;
        pick = $urandom_range(0, 99);
        bias = $urandom_range(0, 99);
        span = (slots > 4095) ? 4095 : slots;
        rq.data   = BYTE_W'($urandom_range(0, 255));
        rq.amount = FIELD_W'($urandom_range(0, 4095));
        if (pick < 38)      rq.req = REQ_PUSH;
        else if (pick < 52) rq.req = REQ_READ;
        else if (pick < 62) rq.req = REQ_PEEK;
        else if (pick < 72) rq.req = REQ_SKIP;
        else if (pick < 82) rq.req = REQ_DISCARD;
        else if (pick < 90) rq.req = REQ_QUERY;
        else if (pick < 95) rq.req = REQ_CLEAR;
        else if (pick < 97) rq.req = REQ_UNUSED;
        else                rq.req = REQ_PUSH;
        if (rq.req == REQ_READ || rq.req == REQ_PEEK) begin
            if (bias < 60) begin
                rq.amount = FIELD_W'($urandom_range(0, 70));
            end else if (bias >= 75) begin
                case ($urandom_range(0, 3))
                    0:       rq.amount = '0;
                    1:       rq.amount = FIELD_W'(MAX_BURST);
                    2:       rq.amount = FIELD_W'(MAX_BURST + 1);
                    default: rq.amount = '1;
                endcase
            end
        end else if (rq.req == REQ_SKIP || rq.req == REQ_DISCARD) begin
            if (bias < 50)      rq.amount = FIELD_W'($urandom_range(0, span));
            else if (bias < 75) rq.amount = FIELD_W'($urandom_range(0, 20));
        end
        return rq;
    endfunction

    // Gap after an item: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!jitter_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Wait until every request is in and every result is out, then let it settle
    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write; the block resets both pointers on it
    task automatic write_size(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_size  = value;
        shadow_front = 0;
        shadow_rear  = 0;
        cfg_valid   <= 1'b0;
    endtask

    task automatic log_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
        error_count++;
        $display("mismatch at result %0d: %s got %0d want %0d",
                 result_count, what, got, want);
    endtask

    // ---- request driver -----------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        logic free_to_load;
        free_to_load = !in_valid;
        if (in_valid && !o_in_stall) begin
            predict_request(cur_request);
            free_to_load = 1'b1;
        end
        if (!free_to_load) begin
            // stalled: payload held as is
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
            cur_request = pending_requests.pop_front();
            in_valid  <= 1'b1;
            in_req    <= cur_request.req;
            in_data   <= cur_request.data;
            in_amount <= cur_request.amount;
            gap_left  = pick_gap();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // ---- result-side stall --------------------------------------------------
    always @(posedge i_clk) begin : result_stall
        int unsigned r;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_seen != hold_asked) begin
            // long hold-off so the block backs up into its input
            hold_seen <= hold_asked;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end else if (!jitter_on) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                stall_left <= $urandom_range(0, 2);
                out_stall  <= 1'b1;
            end else if (r < 12) begin
                stall_left <= $urandom_range(8, 40);
                out_stall  <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ---- result monitor -----------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_brb_result want;
        if (o_out_valid === 1'b1 && !out_stall) begin
            result_count++;
            if (expected_results.size() == 0) begin
                log_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_byte !== want.out_byte)
                    log_mismatch("out_byte", o_out_byte, want.out_byte);
                if (o_byte_valid !== want.byte_valid)
                    log_mismatch("byte_valid", o_byte_valid, want.byte_valid);
                if (o_last !== want.last_flag)
                    log_mismatch("last", o_last, want.last_flag);
                if (o_moved_count !== want.moved)
                    log_mismatch("moved_count", o_moved_count, want.moved);
                if (o_used_size !== want.used)
                    log_mismatch("used_size", o_used_size, want.used);
                if (o_free_size !== want.room)
                    log_mismatch("free_size", o_free_size, want.room);
                if (o_contig_push !== want.push_span)
                    log_mismatch("contig_push", o_contig_push, want.push_span);
                if (o_contig_pop !== want.pop_span)
                    log_mismatch("contig_pop", o_contig_pop, want.pop_span);
            end
        end
    end

    // ---- watchdog -----------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_byte_ring_buffer_unit: errors");
            $finish;
        end
    end

    // ---- stimulus -----------------------------------------------------------
    initial begin : stimulus
        logic [CFG_W-1:0] size_plan [$];
        int unsigned k, j;
        for (k = 0; k < DEPTH; k++) shadow_store[k] = '0;
        size_plan = '{13'd2, 13'd0, 13'd4096, 13'd1, 13'd3, 13'd8191, 13'd17,
                      13'd4095, 13'd64, 13'd5, 13'd200};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset slot count; the block clears its store first
        pending_requests.push_back(make_request(REQ_QUERY,   8'h00, 12'd0));
        pending_requests.push_back(make_request(REQ_READ,    8'h00, 12'd5));    // empty read
        pending_requests.push_back(make_request(REQ_PEEK,    8'hFF, 12'd0));    // empty peek
        pending_requests.push_back(make_request(REQ_PUSH,    8'h00, 12'd0));
        pending_requests.push_back(make_request(REQ_PUSH,    8'hFF, 12'hFFF));
        pending_requests.push_back(make_request(REQ_PUSH,    8'hA5, 12'd0));
        pending_requests.push_back(make_request(REQ_PUSH,    8'h5A, 12'd0));
        pending_requests.push_back(make_request(REQ_PEEK,    8'h00, 12'hFFF));  // capped at held
        pending_requests.push_back(make_request(REQ_READ,    8'h00, 12'd0));    // zero amount
        pending_requests.push_back(make_request(REQ_READ,    8'h00, 12'd2));
        pending_requests.push_back(make_request(REQ_SKIP,    8'h00, 12'hFFF));  // clipped, fills
        pending_requests.push_back(make_request(REQ_PUSH,    8'h3C, 12'd0));    // full: dropped
        pending_requests.push_back(make_request(REQ_PEEK,    8'h00, 12'd70));   // burst cap
        pending_requests.push_back(make_request(REQ_DISCARD, 8'h00, 12'hFFF));  // clipped, empties
        pending_requests.push_back(make_request(REQ_UNUSED,  8'hFF, 12'hFFF));
        pending_requests.push_back(make_request(REQ_SKIP,    8'h00, 12'd100));
        pending_requests.push_back(make_request(REQ_READ,    8'h00, 12'd64));   // stale slots
        pending_requests.push_back(make_request(REQ_PUSH,    8'h81, 12'd0));
        pending_requests.push_back(make_request(REQ_CLEAR,   8'h00, 12'd0));
        pending_requests.push_back(make_request(REQ_QUERY,   8'h00, 12'd0));
        pending_requests.push_back(make_request(REQ_DISCARD, 8'h00, 12'd0));
        pending_requests.push_back(make_request(REQ_SKIP,    8'h00, 12'd0));
        pending_requests.push_back(make_request(REQ_PUSH,    8'h7E, 12'd0));

        // Random phases, each after a size write from the plan
        for (k = 0; k < size_plan.size(); k++) begin
            wait_idle();
            write_size(size_plan[k]);
            jitter_on <= (k % 4 != 3);
            for (j = 0; j < 33; j++) pending_requests.push_back(rand_request(slot_count()));
            if (size_plan[k] == 13'd4096) begin
                // back-pressure: result side held off while pushes keep coming
                wait_idle();
                jitter_on  <= 1'b0;
                hold_asked <= hold_asked + 1;
                for (j = 0; j < 40; j++)
                    pending_requests.push_back(
                        make_request(REQ_PUSH, BYTE_W'($urandom_range(0, 255)), 12'd0));
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("tb_byte_ring_buffer_unit: clean");
        end else begin
            $display("tb_byte_ring_buffer_unit: errors");
        end
        $finish;
    end

endmodule
